// ===== src/otsu_pkg.sv =====
`default_nettype none

package otsu_pkg;

   // Grey levels and the width of a level.
   localparam int LEVELS     = 256;
   localparam int LEVEL_W    = 8;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 8'd255;

   // Default pixel limit of one image.
   localparam int MAX_PIXELS_DEF = 16384;

   // Multiplier digit: bits of the second operand retired per cycle.
   localparam int DIGIT_W = 4;

   // Histogram access from the threshold search: read one bin and clear it.
   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] addr;
   } sweep_req_type;

endpackage

`default_nettype wire

// ===== src/otsu_threshold_top.sv =====
`default_nettype none

// Channel   Direction  Ports                                  Content of one beat
// req       in         req_valid, req_stall, req_pixel,       one grey pixel, last one flagged
//                      req_last_pixel
// rsp       out        rsp_valid, rsp_stall, rsp_threshold    threshold of one finished image
//
// Pixels are taken one per cycle while req_stall is low. After the flagged pixel, req_stall
// stays high while the threshold search walks the bins from the lowest to the highest level
// seen. In the one-level and adjacent-level cases each bin is only read and summed; otherwise
// each bin below the highest level also goes through the variance compare, whose products
// come from digit-serial multipliers. After reset, req_stall is high while the histogram
// is cleared. A finished threshold waits in the output register.

module otsu_threshold_top #(
   parameter int MAX_PIXELS = otsu_pkg::MAX_PIXELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [otsu_pkg::LEVEL_W-1:0]  req_pixel,
   input  wire logic                          req_last_pixel,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [otsu_pkg::LEVEL_W-1:0]       rsp_threshold
);
   import otsu_pkg::*;

   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int SW = CW + LEVEL_W;

   logic               pix_accept;
   logic               hist_ready;
   logic               image_done;
   logic               scan_busy;
   sweep_req_type      sweep;
   logic [CW-1:0]      bin_data;
   logic [CW-1:0]      stat_count;
   logic [SW-1:0]      stat_sum;
   logic [LEVEL_W-1:0] stat_low, stat_high;
   logic               res_valid, res_ready;
   logic [LEVEL_W-1:0] res_level;

   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_threshold_ff;

   // Pixels are held off during the power-up clear and for the whole search, because the
   // search owns the histogram port and empties each bin as it reads it.
   assign req_stall  = !hist_ready || scan_busy;
   assign pix_accept = req_valid && !req_stall;

   otsu_hist #(.MAX_PIXELS(MAX_PIXELS)) u_hist (
      .clock      (clock),
      .reset      (reset),
      .pix_accept (pix_accept),
      .pix_level  (req_pixel),
      .pix_last   (req_last_pixel),
      .sweep      (sweep),
      .bin_data   (bin_data),
      .ready      (hist_ready),
      .image_done (image_done),
      .stat_count (stat_count),
      .stat_sum   (stat_sum),
      .stat_low   (stat_low),
      .stat_high  (stat_high)
   );

   otsu_scan #(.MAX_PIXELS(MAX_PIXELS)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (image_done),
      .stat_count (stat_count),
      .stat_sum   (stat_sum),
      .stat_low   (stat_low),
      .stat_high  (stat_high),
      .sweep      (sweep),
      .bin_data   (bin_data),
      .busy       (scan_busy),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_level  (res_level)
   );

   // The output register frees up in the same cycle its beat is taken.
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_threshold_ff <= res_level;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;

endmodule

`default_nettype wire

// ===== src/otsu_mul.sv =====
`default_nettype none

module otsu_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [AW-1:0]   a,
   input  wire logic [BW-1:0]   b,
   output logic                 done,
   output logic [AW+BW-1:0]     product
);
   import otsu_pkg::*;

   localparam int STEPS = (BW + DIGIT_W - 1) / DIGIT_W;
   localparam int PBW   = STEPS * DIGIT_W;
   localparam int PW    = AW + BW;
   localparam int SCW   = $clog2(STEPS + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [SCW-1:0]    cnt_ff;
   logic [AW-1:0]     a_ff;
   logic [PBW-1:0]    b_ff;
   logic [PW-1:0]     acc_ff;
   logic [AW+DIGIT_W-1:0] part_in;
   logic [PW-1:0]     acc_in;

   // Most significant digit first: shift the partial sum and add a times the digit.
   assign part_in = a_ff * b_ff[PBW-1 -: DIGIT_W];
   assign acc_in  = {acc_ff[PW-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PW'(part_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == SCW'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= PBW'(b);
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= b_ff << DIGIT_W;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== src/otsu_hist.sv =====
`default_nettype none

module otsu_hist #(
   parameter int MAX_PIXELS = otsu_pkg::MAX_PIXELS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  pix_accept,
   input  wire logic [otsu_pkg::LEVEL_W-1:0]          pix_level,
   input  wire logic                                  pix_last,
   input  wire otsu_pkg::sweep_req_type               sweep,
   output logic [$clog2(MAX_PIXELS+1)-1:0]            bin_data,
   output logic                                       ready,
   output logic                                       image_done,
   output logic [$clog2(MAX_PIXELS+1)-1:0]            stat_count,
   output logic [$clog2(MAX_PIXELS+1)+otsu_pkg::LEVEL_W-1:0] stat_sum,
   output logic [otsu_pkg::LEVEL_W-1:0]               stat_low,
   output logic [otsu_pkg::LEVEL_W-1:0]               stat_high
);
   import otsu_pkg::*;

   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int SW = CW + LEVEL_W;

   logic [CW-1:0]      mem_ff [LEVELS];
   logic [CW-1:0]      rd_ff;

   // Power-up clearing pass.
   logic               clr_busy_ff;
   logic [LEVEL_W-1:0] clr_addr_ff;

   // Running statistics of the current image.
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [LEVEL_W-1:0] low_ff, low_in;
   logic [LEVEL_W-1:0] high_ff, high_in;
   logic               counted;

   // Increment stage and the write it made in the previous cycle.
   logic               s1_valid_ff;
   logic [LEVEL_W-1:0] s1_addr_ff;
   logic               wr_valid_ff;
   logic [LEVEL_W-1:0] wr_addr_ff;
   logic [CW-1:0]      wr_data_ff;
   logic [CW-1:0]      inc_in;

   logic               we;
   logic [LEVEL_W-1:0] wa;
   logic [CW-1:0]      wd;
   logic [LEVEL_W-1:0] ra;

   assign counted = pix_accept && (count_ff < CW'(MAX_PIXELS));

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (counted) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + SW'(pix_level);
         if (pix_level < low_ff) begin
            low_in = pix_level;
         end
         if (pix_level > high_ff) begin
            high_in = pix_level;
         end
      end
   end

   // The read of a pixel that follows the same level directly misses that write.
   assign inc_in = ((wr_valid_ff && wr_addr_ff == s1_addr_ff) ? wr_data_ff : rd_ff) + 1'b1;

   assign ra = sweep.valid ? sweep.addr : pix_level;

   always_comb begin
      we = 1'b0;
      wa = s1_addr_ff;
      wd = inc_in;
      priority if (clr_busy_ff) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wd = '0;
      end else if (sweep.valid) begin
         we = 1'b1;
         wa = sweep.addr;
         wd = '0;
      end else if (s1_valid_ff) begin
         we = 1'b1;
      end else begin
         we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rd_ff <= mem_ff[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
         low_ff      <= LEVEL_TOP;
         high_ff     <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LEVEL_TOP) begin
               clr_busy_ff <= 1'b0;
            end
         end
         s1_valid_ff <= counted;
         wr_valid_ff <= s1_valid_ff;
         if (pix_accept && pix_last) begin
            count_ff <= '0;
            sum_ff   <= '0;
            low_ff   <= LEVEL_TOP;
            high_ff  <= '0;
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
            low_ff   <= low_in;
            high_ff  <= high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= pix_level;
      wr_addr_ff <= s1_addr_ff;
      wr_data_ff <= inc_in;
   end

   assign bin_data   = rd_ff;
   assign ready      = !clr_busy_ff;
   assign image_done = pix_accept && pix_last;
   assign stat_count = count_in;
   assign stat_sum   = sum_in;
   assign stat_low   = low_in;
   assign stat_high  = high_in;

endmodule

`default_nettype wire

// ===== src/otsu_scan.sv =====
`default_nettype none

module otsu_scan #(
   parameter int MAX_PIXELS = otsu_pkg::MAX_PIXELS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [$clog2(MAX_PIXELS+1)-1:0]       stat_count,
   input  wire logic [$clog2(MAX_PIXELS+1)+otsu_pkg::LEVEL_W-1:0] stat_sum,
   input  wire logic [otsu_pkg::LEVEL_W-1:0]          stat_low,
   input  wire logic [otsu_pkg::LEVEL_W-1:0]          stat_high,
   output otsu_pkg::sweep_req_type                    sweep,
   input  wire logic [$clog2(MAX_PIXELS+1)-1:0]       bin_data,
   output logic                                       busy,
   output logic                                       res_valid,
   input  wire logic                                  res_ready,
   output logic [otsu_pkg::LEVEL_W-1:0]               res_level
);
   import otsu_pkg::*;

   localparam int CW  = $clog2(MAX_PIXELS + 1);
   localparam int SW  = CW + LEVEL_W;
   localparam int DW  = SW + CW;
   localparam int QW  = 2 * CW;
   localparam int D2W = 2 * DW;
   localparam int PW  = D2W + DW;

   typedef enum logic [3:0] {
      IDLE, WAIT_WR, REQ, ACC, SUMB, PROD, DIFF, SQ_GO, SQ_WAIT, CMP_GO, CMP_WAIT, FIN
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      n_ff;
   logic [SW-1:0]      s_ff;
   logic [LEVEL_W-1:0] hi_ff, t_ff;
   logic               skip_ff;
   logic [CW-1:0]      nb_ff, nf_ff;
   logic [SW-1:0]      sb_ff, ct_ff;
   logic [DW-1:0]      a_ff, b_ff, d_ff;
   logic [QW-1:0]      q_ff, best_q_ff;
   logic [D2W-1:0]     d2_ff, best_d2_ff;
   logic               have_ff;
   logic [LEVEL_W-1:0] best_t_ff;

   logic [SW-1:0]      ct_in;
   logic [DW-1:0]      a_in, b_in, d_in;
   logic [QW-1:0]      q_in;

   logic               mul0_start, mul1_start, mul0_done, mul1_done;
   logic [D2W-1:0]     mul0_a;
   logic [DW-1:0]      mul0_b;
   logic [PW-1:0]      mul0_p, mul1_p;

   assign ct_in = bin_data * t_ff;
   assign a_in  = sb_ff * n_ff;
   assign b_in  = s_ff * nb_ff;
   assign q_in  = nb_ff * nf_ff;
   assign d_in  = (a_ff >= b_ff) ? a_ff - b_ff : b_ff - a_ff;

   // Unit 0 squares the difference, then forms the candidate side of the compare.
   assign mul0_start = (state_ff == SQ_GO) || (state_ff == CMP_GO);
   assign mul1_start = (state_ff == CMP_GO);
   assign mul0_a     = (state_ff == SQ_GO) ? D2W'(d_ff) : d2_ff;
   assign mul0_b     = (state_ff == SQ_GO) ? d_ff : DW'(best_q_ff);

   otsu_mul #(.AW(D2W), .BW(DW)) u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul0_start),
      .a       (mul0_a),
      .b       (mul0_b),
      .done    (mul0_done),
      .product (mul0_p)
   );

   otsu_mul #(.AW(D2W), .BW(DW)) u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (mul1_start),
      .a       (best_d2_ff),
      .b       (DW'(q_ff)),
      .done    (mul1_done),
      .product (mul1_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         have_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  n_ff      <= stat_count;
                  s_ff      <= stat_sum;
                  hi_ff     <= stat_high;
                  t_ff      <= stat_low;
                  best_t_ff <= stat_low;
                  skip_ff   <= {1'b0, stat_high} <= {1'b0, stat_low} + 9'd1;
                  nb_ff     <= '0;
                  sb_ff     <= '0;
                  have_ff   <= 1'b0;
                  state_ff  <= WAIT_WR;
               end
            end
            WAIT_WR: state_ff <= REQ;
            REQ:     state_ff <= ACC;
            ACC: begin
               nb_ff <= nb_ff + bin_data;
               ct_ff <= ct_in;
               priority if (t_ff >= hi_ff) begin
                  state_ff <= FIN;
               end else if (skip_ff) begin
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= REQ;
               end else begin
                  state_ff <= SUMB;
               end
            end
            SUMB: begin
               sb_ff    <= sb_ff + ct_ff;
               nf_ff    <= n_ff - nb_ff;
               state_ff <= PROD;
            end
            PROD: begin
               a_ff     <= a_in;
               b_ff     <= b_in;
               q_ff     <= q_in;
               state_ff <= DIFF;
            end
            DIFF: begin
               d_ff     <= d_in;
               state_ff <= SQ_GO;
            end
            SQ_GO: state_ff <= SQ_WAIT;
            SQ_WAIT: begin
               if (mul0_done) begin
                  d2_ff <= mul0_p[D2W-1:0];
                  priority if (q_ff == '0) begin
                     t_ff     <= t_ff + 1'b1;
                     state_ff <= REQ;
                  end else if (!have_ff) begin
                     have_ff    <= 1'b1;
                     best_d2_ff <= mul0_p[D2W-1:0];
                     best_q_ff  <= q_ff;
                     best_t_ff  <= t_ff;
                     t_ff       <= t_ff + 1'b1;
                     state_ff   <= REQ;
                  end else begin
                     state_ff <= CMP_GO;
                  end
               end
            end
            CMP_GO: state_ff <= CMP_WAIT;
            CMP_WAIT: begin
               if (mul0_done && mul1_done) begin
                  if (mul0_p > mul1_p) begin
                     best_d2_ff <= d2_ff;
                     best_q_ff  <= q_ff;
                     best_t_ff  <= t_ff;
                  end
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= REQ;
               end
            end
            FIN: begin
               if (res_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign sweep.valid = (state_ff == REQ);
   assign sweep.addr  = t_ff;
   assign busy        = (state_ff != IDLE);
   assign res_valid   = (state_ff == FIN);
   assign res_level   = best_t_ff;

endmodule

`default_nettype wire
